// ===== rtl/bvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared types, sizes and constants for the battery voltage supervisor.
// ----------------------------------------------------------------------------
package bvs_pkg;

  // field widths
  localparam int VOLT_W  = 10;
  localparam int SOC_W   = 7;
  localparam int LEVEL_W = 4;
  localparam int VOLT_MAX = (1 << VOLT_W) - 1;

  // sizing of the averaging window, vote group and outlier filter
  localparam int WINDOW_DEPTH = 20;
  localparam int VOTE_TICKS   = 3;
  localparam int REJECT_LIMIT = 5;

  localparam int TICK_W = $clog2(VOTE_TICKS + 1);
  localparam int REJ_W  = $clog2(REJECT_LIMIT + 1);
  localparam int VOTE_HALF = VOTE_TICKS / 2;

  // running sum and reciprocal multiply for the window average
  localparam int SUM_W     = $clog2(VOLT_MAX * WINDOW_DEPTH + 1);
  localparam int AVG_SHIFT = SUM_W + 2 * $clog2(WINDOW_DEPTH);
  localparam int MULT_W    = AVG_SHIFT - $clog2(WINDOW_DEPTH) + 1;
  localparam int AVG_MULT  = ((1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int PROD_W    = SUM_W + MULT_W;

  // fixed rule constants
  localparam int OUTLIER_MARGIN   = 5;
  localparam int SHUTDOWN_REPEATS = 6;
  localparam int REMINDER_REPEATS = 5;
  localparam int NORMAL_REPEATS   = 2;
  localparam int NORMAL_SAT       = 3;
  localparam int LEVEL_STEP       = 10;
  localparam int LEVEL_OFFSET     = 5;
  localparam int LEVEL_MAX        = 9;

  // counter widths
  localparam int SD_W = 3;
  localparam int RM_W = 3;
  localparam int NM_W = 2;

  // configuration register indexes
  localparam logic REG_SHUTDOWN_LEVEL = 1'b0;
  localparam logic REG_WARNING_LEVEL  = 1'b1;

  // reset values of the configuration registers
  localparam logic [VOLT_W-1:0] SHUTDOWN_LEVEL_RST = VOLT_W'(340);
  localparam logic [VOLT_W-1:0] WARNING_LEVEL_RST  = VOLT_W'(350);

  // battery status codes
  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_WARNING  = 2'd1,
    ST_LOWPOWER = 2'd2
  } status_t;

  // phone level: count the 10 percent steps above the 5 percent offset
  function automatic logic [LEVEL_W-1:0] level_of(input logic [SOC_W-1:0] pct);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int k = 1; k <= LEVEL_MAX; k++) begin
      if (int'(pct) >= LEVEL_STEP * k + LEVEL_OFFSET) begin
        lvl = lvl + LEVEL_W'(1);
      end
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/battery_voltage_supervisor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_supervisor_top
// Smooths battery samples, keeps a sliding average with outlier rejection,
// votes on low-voltage thresholds and raises power status events.
// ----------------------------------------------------------------------------
// The result beat is registered in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the result register is the only stage, so
// in_stall follows a held result (out_valid and out_stall).
// Reset: synchronous, active high; clears all state, the window and the
// result valid flag, and loads 340 / 350 into the threshold registers.
module battery_voltage_supervisor_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bvs_pkg::VOLT_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bvs_pkg::VOLT_W-1:0]     voltage_sample,
  input  logic                           comparator_low,
  input  logic                           charger_online,
  input  logic [bvs_pkg::SOC_W-1:0]      soc_percent,
  input  logic                           reminder_active,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bvs_pkg::VOLT_W-1:0]     smoothed_out,
  output logic [bvs_pkg::VOLT_W-1:0]     average_out,
  output logic [bvs_pkg::LEVEL_W-1:0]    phone_level,
  output logic [1:0]                     status_out,
  output logic                           shutdown_event,
  output logic                           warning_event,
  output logic                           normal_event,
  output logic                           charging_event,
  output logic                           change_event
);

  localparam int VW = bvs_pkg::VOLT_W;
  localparam int SW = bvs_pkg::SUM_W;
  localparam int TW = bvs_pkg::TICK_W;

  // configuration registers
  logic [VW-1:0] shutdown_level;
  logic [VW-1:0] warning_level;

  // filter state
  logic [VW-1:0] smoothed_voltage;
  logic [VW-1:0] avg_window [bvs_pkg::WINDOW_DEPTH];
  logic [SW-1:0] window_sum;
  logic [VW-1:0] window_average;
  logic [bvs_pkg::REJ_W-1:0] reject_count;

  // vote and status state
  logic [TW-1:0] tick_count;
  logic [TW-1:0] off_votes;
  logic [TW-1:0] warn_votes;
  logic [bvs_pkg::RM_W-1:0] reminder_count;
  logic [bvs_pkg::SD_W-1:0] shutdown_count;
  logic [bvs_pkg::NM_W-1:0] normal_count;
  logic charger_seen;
  logic first_reminder;
  bvs_pkg::status_t battery_status;
  logic [bvs_pkg::LEVEL_W-1:0] last_level;

  // next values
  logic [VW-1:0] smoothed_next;
  logic [VW:0]   smoothed_sum;
  logic [bvs_pkg::SOC_W-1:0] level_pct;
  logic [bvs_pkg::LEVEL_W-1:0] level;
  logic [VW-1:0] avg_diff;
  logic          outlier;
  logic [bvs_pkg::REJ_W:0] reject_inc;
  logic          push;
  logic          fill;
  logic [SW-1:0] window_sum_next;
  logic [bvs_pkg::PROD_W-1:0] avg_prod;
  logic [VW-1:0] window_average_next;
  logic [bvs_pkg::REJ_W-1:0] reject_count_next;

  logic          off_vote;
  logic          warn_vote;
  logic [TW-1:0] tick_inc;
  logic [TW-1:0] off_total;
  logic [TW-1:0] warn_total;
  logic          evaluate;
  logic [TW-1:0] tick_count_next;
  logic [TW-1:0] off_votes_next;
  logic [TW-1:0] warn_votes_next;
  logic [bvs_pkg::RM_W-1:0] reminder_count_next;
  logic [bvs_pkg::SD_W-1:0] shutdown_count_next;
  logic [bvs_pkg::NM_W-1:0] normal_count_next;
  logic charger_seen_next;
  logic first_reminder_next;
  bvs_pkg::status_t battery_status_next;
  logic [bvs_pkg::LEVEL_W-1:0] last_level_next;
  logic ev_off, ev_warn, ev_norm, ev_chg, ev_change;

  logic in_accept;

  // handshake: a held result blocks the next beat
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // two-point smoothing, sample taken as is while the smoother is zero
  assign smoothed_sum  = {1'b0, voltage_sample} + {1'b0, smoothed_voltage};
  assign smoothed_next = (smoothed_voltage == '0) ? voltage_sample : smoothed_sum[VW:1];

  // phone level, forced to zero at or below the shutdown threshold
  assign level_pct = (smoothed_next <= shutdown_level) ? '0 : soc_percent;
  assign level     = bvs_pkg::level_of(level_pct);

  // outlier test against the current window average
  assign avg_diff = (window_average > smoothed_next) ? window_average - smoothed_next
                                                     : smoothed_next - window_average;
  assign outlier    = (window_average != '0) && (avg_diff > VW'(bvs_pkg::OUTLIER_MARGIN));
  assign reject_inc = {1'b0, reject_count} + (bvs_pkg::REJ_W + 1)'(1);
  assign push       = ~outlier || (reject_inc >= (bvs_pkg::REJ_W + 1)'(bvs_pkg::REJECT_LIMIT));
  assign reject_count_next = push ? '0 : reject_inc[bvs_pkg::REJ_W-1:0];

  // window fill or shift, tracked by a running sum
  assign fill = (avg_window[0] == '0);
  assign window_sum_next = fill
      ? SW'(smoothed_next) * SW'(bvs_pkg::WINDOW_DEPTH)
      : window_sum - SW'(avg_window[0]) + SW'(smoothed_next);

  // sum / depth by reciprocal multiply; a filled window averages to its value
  assign avg_prod = bvs_pkg::PROD_W'(window_sum_next)
                  * bvs_pkg::PROD_W'(bvs_pkg::AVG_MULT);
  assign window_average_next = fill ? smoothed_next : avg_prod[bvs_pkg::AVG_SHIFT +: VW];

  // votes for this tick
  assign off_vote   = comparator_low | (smoothed_next <= shutdown_level);
  assign warn_vote  = smoothed_next <= warning_level;
  assign tick_inc   = tick_count + TW'(1);
  assign off_total  = off_votes + TW'(off_vote);
  assign warn_total = warn_votes + TW'(warn_vote);
  assign evaluate   = tick_inc >= TW'(bvs_pkg::VOTE_TICKS);

  // status decision at the end of each vote group
  always_comb begin
    tick_count_next     = tick_inc;
    off_votes_next      = off_total;
    warn_votes_next     = warn_total;
    reminder_count_next = reminder_count;
    shutdown_count_next = shutdown_count;
    normal_count_next   = normal_count;
    charger_seen_next   = charger_seen;
    first_reminder_next = first_reminder;
    battery_status_next = battery_status;
    last_level_next     = last_level;
    ev_off    = 1'b0;
    ev_warn   = 1'b0;
    ev_norm   = 1'b0;
    ev_chg    = 1'b0;
    ev_change = 1'b0;
    if (evaluate) begin
      tick_count_next = '0;
      off_votes_next  = '0;
      warn_votes_next = '0;
      if (!charger_online) begin
        priority if (off_total > TW'(bvs_pkg::VOTE_HALF)) begin
          shutdown_count_next = shutdown_count + bvs_pkg::SD_W'(1);
          reminder_count_next = '0;
          normal_count_next   = '0;
          battery_status_next = bvs_pkg::ST_LOWPOWER;
          if (shutdown_count_next > bvs_pkg::SD_W'(bvs_pkg::SHUTDOWN_REPEATS)) begin
            shutdown_count_next = '0;
            ev_off = 1'b1;
          end
        end else if (warn_total > TW'(bvs_pkg::VOTE_HALF)) begin
          reminder_count_next = reminder_count + bvs_pkg::RM_W'(1);
          shutdown_count_next = '0;
          normal_count_next   = '0;
          battery_status_next = bvs_pkg::ST_WARNING;
          if ((first_reminder && reminder_count_next > bvs_pkg::RM_W'(1)) ||
              (!first_reminder &&
               reminder_count_next >= bvs_pkg::RM_W'(bvs_pkg::REMINDER_REPEATS))) begin
            first_reminder_next = 1'b0;
            reminder_count_next = '0;
            ev_warn = ~reminder_active;
          end
        end else begin
          if (normal_count < bvs_pkg::NM_W'(bvs_pkg::NORMAL_SAT)) begin
            normal_count_next = normal_count + bvs_pkg::NM_W'(1);
          end
          reminder_count_next = '0;
          shutdown_count_next = '0;
          if (normal_count_next > bvs_pkg::NM_W'(bvs_pkg::NORMAL_REPEATS) &&
              battery_status != bvs_pkg::ST_NORMAL) begin
            battery_status_next = bvs_pkg::ST_NORMAL;
            ev_norm = 1'b1;
          end
        end
      end else begin
        ev_chg = 1'b1;
      end
      // level and charger change tracking, frozen in low power
      if (battery_status_next != bvs_pkg::ST_LOWPOWER) begin
        ev_change         = (level != last_level) || (charger_seen != charger_online);
        charger_seen_next = charger_online;
        last_level_next   = level;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_level <= bvs_pkg::SHUTDOWN_LEVEL_RST;
      warning_level  <= bvs_pkg::WARNING_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bvs_pkg::REG_SHUTDOWN_LEVEL: shutdown_level <= cfg_data;
        bvs_pkg::REG_WARNING_LEVEL:  warning_level  <= cfg_data;
      endcase
    end
  end

  // supervisor state, updated on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_voltage <= '0;
      for (int i = 0; i < bvs_pkg::WINDOW_DEPTH; i++) begin
        avg_window[i] <= '0;
      end
      window_sum     <= '0;
      window_average <= '0;
      reject_count   <= '0;
      tick_count     <= '0;
      off_votes      <= '0;
      warn_votes     <= '0;
      reminder_count <= '0;
      shutdown_count <= '0;
      normal_count   <= '0;
      charger_seen   <= 1'b0;
      first_reminder <= 1'b1;
      battery_status <= bvs_pkg::ST_NORMAL;
      last_level     <= bvs_pkg::LEVEL_W'(bvs_pkg::LEVEL_MAX);
    end else if (in_accept) begin
      smoothed_voltage <= smoothed_next;
      reject_count     <= reject_count_next;
      if (push) begin
        for (int i = 0; i < bvs_pkg::WINDOW_DEPTH - 1; i++) begin
          avg_window[i] <= fill ? smoothed_next : avg_window[i + 1];
        end
        avg_window[bvs_pkg::WINDOW_DEPTH - 1] <= smoothed_next;
        window_sum     <= window_sum_next;
        window_average <= window_average_next;
      end
      tick_count     <= tick_count_next;
      off_votes      <= off_votes_next;
      warn_votes     <= warn_votes_next;
      reminder_count <= reminder_count_next;
      shutdown_count <= shutdown_count_next;
      normal_count   <= normal_count_next;
      charger_seen   <= charger_seen_next;
      first_reminder <= first_reminder_next;
      battery_status <= battery_status_next;
      last_level     <= last_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept | (out_valid & out_stall);
    end
    if (in_accept) begin
      smoothed_out   <= smoothed_next;
      average_out    <= push ? window_average_next : window_average;
      phone_level    <= level;
      status_out     <= battery_status_next;
      shutdown_event <= ev_off;
      warning_event  <= ev_warn;
      normal_event   <= ev_norm;
      charging_event <= ev_chg;
      change_event   <= ev_change;
    end
  end

endmodule

// ===== rtl/bvs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvs_checker
// Port-level checks on the battery voltage supervisor, bound to the top.
// ----------------------------------------------------------------------------
module bvs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bvs_pkg::VOLT_W-1:0]     smoothed_out,
  input logic [bvs_pkg::VOLT_W-1:0]     average_out,
  input logic [1:0]                     status_out,
  input logic                           shutdown_event,
  input logic                           warning_event,
  input logic                           normal_event,
  input logic                           charging_event
);

  // input side only waits on a held result
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // every accepted beat yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // a held result keeps its smoothed and average payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(smoothed_out) && $stable(average_out)))
    else $error("stalled result changed");

  // shutdown request only comes with low-power status
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && shutdown_event) |-> (status_out == bvs_pkg::ST_LOWPOWER))
    else $error("shutdown event outside low-power status");

  // the group decision raises at most one of these events
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({shutdown_event, warning_event, normal_event, charging_event}))
    else $error("conflicting status events");

endmodule

bind battery_voltage_supervisor_top bvs_checker u_bvs_checker (.*);

// ===== sim/tb_battery_voltage_supervisor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_voltage_supervisor_top
// Self-checking bench for the battery voltage supervisor. A queue-fed driver
// sends sample beats with random gaps, and a monitor applies random stall and
// checks every result beat field by field. The expected beats come from a
// cycle-free copy of the smoothing, window and voting behavior that the bench
// runs on each accepted sample. The run steps through several threshold
// settings, including both extremes, and changes them only while idle.
// ----------------------------------------------------------------------------
module tb_battery_voltage_supervisor_top;

  // sizes and rule constants taken from the package
  localparam int VOLT_W           = bvs_pkg::VOLT_W;
  localparam int SOC_W            = bvs_pkg::SOC_W;
  localparam int LEVEL_W          = bvs_pkg::LEVEL_W;
  localparam int VOLT_MAX         = bvs_pkg::VOLT_MAX;
  localparam int WINDOW_DEPTH     = bvs_pkg::WINDOW_DEPTH;
  localparam int VOTE_TICKS       = bvs_pkg::VOTE_TICKS;
  localparam int REJECT_LIMIT     = bvs_pkg::REJECT_LIMIT;
  localparam int TICK_W           = bvs_pkg::TICK_W;
  localparam int REJ_W            = bvs_pkg::REJ_W;
  localparam int VOTE_HALF        = bvs_pkg::VOTE_HALF;
  localparam int OUTLIER_MARGIN   = bvs_pkg::OUTLIER_MARGIN;
  localparam int SHUTDOWN_REPEATS = bvs_pkg::SHUTDOWN_REPEATS;
  localparam int REMINDER_REPEATS = bvs_pkg::REMINDER_REPEATS;
  localparam int NORMAL_REPEATS   = bvs_pkg::NORMAL_REPEATS;
  localparam int NORMAL_SAT       = bvs_pkg::NORMAL_SAT;
  localparam int LEVEL_STEP       = bvs_pkg::LEVEL_STEP;
  localparam int LEVEL_OFFSET     = bvs_pkg::LEVEL_OFFSET;
  localparam int LEVEL_MAX        = bvs_pkg::LEVEL_MAX;
  localparam int SD_W             = bvs_pkg::SD_W;
  localparam int RM_W             = bvs_pkg::RM_W;
  localparam int NM_W             = bvs_pkg::NM_W;

  localparam int SOC_TOP = (1 << SOC_W) - 1;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic              cmp_low;
    logic              charger;
    logic [SOC_W-1:0]  soc;
    logic              reminder;
    logic              drain;   // hold this beat until all results are back
  } sample_beat_t;

  typedef struct packed {
    logic [VOLT_W-1:0]  smoothed;
    logic [VOLT_W-1:0]  average;
    logic [LEVEL_W-1:0] level;
    bvs_pkg::status_t   status;
    logic               shutdown_ev;
    logic               warning_ev;
    logic               normal_ev;
    logic               charging_ev;
    logic               change_ev;
  } supervisor_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [VOLT_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VOLT_W-1:0]  voltage_sample = '0;
  logic               comparator_low = 1'b0;
  logic               charger_online = 1'b0;
  logic [SOC_W-1:0]   soc_percent = '0;
  logic               reminder_active = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VOLT_W-1:0]  smoothed_out;
  logic [VOLT_W-1:0]  average_out;
  logic [LEVEL_W-1:0] phone_level;
  logic [1:0]         status_out;
  logic               shutdown_event;
  logic               warning_event;
  logic               normal_event;
  logic               charging_event;
  logic               change_event;

  battery_voltage_supervisor_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .voltage_sample  (voltage_sample),
    .comparator_low  (comparator_low),
    .charger_online  (charger_online),
    .soc_percent     (soc_percent),
    .reminder_active (reminder_active),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .smoothed_out    (smoothed_out),
    .average_out     (average_out),
    .phone_level     (phone_level),
    .status_out      (status_out),
    .shutdown_event  (shutdown_event),
    .warning_event   (warning_event),
    .normal_event    (normal_event),
    .charging_event  (charging_event),
    .change_event    (change_event)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // supervisor state mirrored by the bench
  logic [VOLT_W-1:0]  thr_shutdown;
  logic [VOLT_W-1:0]  thr_warning;
  logic [VOLT_W-1:0]  supv_smooth;
  logic [VOLT_W-1:0]  supv_window [WINDOW_DEPTH];
  logic [VOLT_W-1:0]  supv_average;
  logic [REJ_W-1:0]   supv_rejects;
  logic [TICK_W-1:0]  supv_ticks;
  logic [TICK_W-1:0]  supv_off_votes;
  logic [TICK_W-1:0]  supv_warn_votes;
  logic [RM_W-1:0]    supv_reminders;
  logic [SD_W-1:0]    supv_shutdowns;
  logic [NM_W-1:0]    supv_normals;
  logic               supv_charger_seen;
  logic               supv_first_reminder;
  bvs_pkg::status_t   supv_status;
  logic [LEVEL_W-1:0] supv_last_level;

  sample_beat_t        sample_backlog [$];
  supervisor_reading_t pending_readings [$];
  sample_beat_t        cur_beat;

  int error_count = 0;
  int beats_taken = 0;
  int results_done = 0;
  int settings_used = 0;
  int in_pause_left = 0;
  int in_calm_left = 0;
  int out_stall_left = 0;
  int out_calm_left = 0;
  int n_shutdown = 0;
  int n_warning = 0;
  int n_normal = 0;
  int n_charging = 0;
  int n_change = 0;

  // advance the mirrored state by one sample and return its reading
  function automatic supervisor_reading_t supervise_sample(input sample_beat_t b);
    supervisor_reading_t r;
    logic [VOLT_W:0]     pair_sum;
    logic [VOLT_W-1:0]   diff;
    logic [SOC_W-1:0]    pct;
    logic [LEVEL_W-1:0]  lvl;
    logic                take;
    int                  steps;
    int                  win_sum;
    r = '0;

    // two-point smoothing, an empty smoother loads the sample as is
    if (supv_smooth == '0) begin
      supv_smooth = b.volts;
    end else begin
      pair_sum = {1'b0, b.volts} + {1'b0, supv_smooth};
      supv_smooth = pair_sum[VOLT_W:1];
    end

    // phone level, forced to zero at or below the shutdown threshold
    pct = (supv_smooth <= thr_shutdown) ? '0 : b.soc;
    if (pct < LEVEL_OFFSET) begin
      lvl = '0;
    end else begin
      steps = (int'(pct) - LEVEL_OFFSET) / LEVEL_STEP;
      lvl = (steps > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(steps);
    end

    // sliding window with outlier rejection
    diff = (supv_average > supv_smooth) ? supv_average - supv_smooth
                                        : supv_smooth - supv_average;
    take = 1'b1;
    if (diff > OUTLIER_MARGIN && supv_average != '0) begin
      supv_rejects = supv_rejects + 1'b1;
      if (supv_rejects < REJECT_LIMIT) take = 1'b0;
    end
    if (take) begin
      supv_rejects = '0;
      if (supv_window[0] == '0) begin
        // empty window fills with the new value
        for (int i = 0; i < WINDOW_DEPTH; i++) supv_window[i] = supv_smooth;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) supv_window[i] = supv_window[i + 1];
        supv_window[WINDOW_DEPTH - 1] = supv_smooth;
      end
      win_sum = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_sum = win_sum + int'(supv_window[i]);
      supv_average = VOLT_W'(win_sum / WINDOW_DEPTH);
    end

    // gather votes for this group
    supv_ticks = supv_ticks + 1'b1;
    if (b.cmp_low || supv_smooth <= thr_shutdown) supv_off_votes = supv_off_votes + 1'b1;
    if (supv_smooth <= thr_warning) supv_warn_votes = supv_warn_votes + 1'b1;

    // end of a vote group
    if (supv_ticks >= VOTE_TICKS) begin
      if (!b.charger) begin
        if (supv_off_votes > VOTE_HALF) begin
          supv_shutdowns = supv_shutdowns + 1'b1;
          supv_reminders = '0;
          supv_normals = '0;
          supv_status = bvs_pkg::ST_LOWPOWER;
          if (supv_shutdowns > SHUTDOWN_REPEATS) begin
            supv_shutdowns = '0;
            r.shutdown_ev = 1'b1;
          end
        end else if (supv_warn_votes > VOTE_HALF) begin
          supv_reminders = supv_reminders + 1'b1;
          supv_shutdowns = '0;
          supv_normals = '0;
          supv_status = bvs_pkg::ST_WARNING;
          // first reminder comes sooner than the repeats
          if ((supv_first_reminder && supv_reminders > 1) ||
              (!supv_first_reminder && supv_reminders >= REMINDER_REPEATS)) begin
            supv_first_reminder = 1'b0;
            supv_reminders = '0;
            if (!b.reminder) r.warning_ev = 1'b1;
          end
        end else begin
          if (supv_normals < NORMAL_SAT) supv_normals = supv_normals + 1'b1;
          supv_reminders = '0;
          supv_shutdowns = '0;
          if (supv_normals > NORMAL_REPEATS && supv_status != bvs_pkg::ST_NORMAL) begin
            supv_status = bvs_pkg::ST_NORMAL;
            r.normal_ev = 1'b1;
          end
        end
      end else begin
        r.charging_ev = 1'b1;
      end
      supv_ticks = '0;
      supv_off_votes = '0;
      supv_warn_votes = '0;

      // low power freezes the level and charger record
      if (supv_status != bvs_pkg::ST_LOWPOWER) begin
        if (lvl != supv_last_level || supv_charger_seen != b.charger) r.change_ev = 1'b1;
        supv_charger_seen = b.charger;
        supv_last_level = lvl;
      end
    end

    r.smoothed = supv_smooth;
    r.average  = supv_average;
    r.level    = lvl;
    r.status   = supv_status;
    return r;
  endfunction

  // idle length for either side: mostly short, sometimes long, with calm runs
  function automatic int next_pause(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    roll = $urandom_range(199);
    if (roll < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (roll < 110) return 0;
    if (roll < 175) return $urandom_range(1, 3);
    if (roll < 195) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void queue_beat(input int v, input logic c, input logic g,
                                     input int s, input logic r, input logic d);
    sample_beat_t b;
    b.volts    = VOLT_W'(v);
    b.cmp_low  = c;
    b.charger  = g;
    b.soc      = SOC_W'(s);
    b.reminder = r;
    b.drain    = d;
    sample_backlog.push_back(b);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int idx,
                               input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, expected %0d", idx, name, got, want));
  endtask

  // threshold write, only issued while the block is idle
  task automatic cfg_write(input logic idx, input logic [VOLT_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == bvs_pkg::REG_SHUTDOWN_LEVEL) thr_shutdown = data;
    else thr_warning = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || in_valid || pending_readings.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // runs of samples that dwell around a target, so vote groups repeat
  task automatic queue_episodes(input int count);
    int   made, run, target, v, roll, soc_base, chg_mode, cmp_rate;
    logic chg, first_drain;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (roll < 20) target = int'(thr_shutdown) + int'($urandom_range(10)) - 5;
      else if (roll < 30) target = int'(thr_shutdown) - int'($urandom_range(5, 40));
      else if (roll < 50) target = int'(thr_warning) + int'($urandom_range(10)) - 5;
      else if (roll < 75) target = int'(thr_warning) + int'($urandom_range(6, 60));
      else if (roll < 88) target = $urandom_range(VOLT_MAX);
      else if (roll < 93) target = VOLT_MAX;
      else target = $urandom_range(3);
      run = $urandom_range(6, 40);
      chg_mode = $urandom_range(99);
      cmp_rate = ($urandom_range(9) == 0) ? 80 : 3;
      soc_base = ($urandom_range(3) == 0) ? $urandom_range(SOC_TOP) : $urandom_range(100);
      first_drain = ($urandom_range(19) == 0);
      for (int k = 0; k < run; k++) begin
        v = target + int'($urandom_range(6)) - 3;
        // occasional spike for the outlier filter
        if ($urandom_range(24) == 0) v = target + int'($urandom_range(300)) - 150;
        if (v < 0) v = 0;
        if (v > VOLT_MAX) v = VOLT_MAX;
        if ($urandom_range(4) == 0) soc_base = soc_base + int'($urandom_range(4)) - 2;
        if (soc_base < 0) soc_base = 0;
        if (soc_base > SOC_TOP) soc_base = SOC_TOP;
        if (chg_mode < 70) chg = 1'b0;
        else if (chg_mode < 85) chg = 1'b1;
        else chg = ($urandom_range(1) != 0);
        queue_beat(v, $urandom_range(99) < cmp_rate, chg, soc_base,
                   $urandom_range(2) == 0, first_drain && k == 0);
      end
      made = made + run;
    end
  endtask

  // input driver: one beat at a time from the backlog
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_pause_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_readings.push_back(supervise_sample(cur_beat));
        beats_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (sample_backlog.size() != 0 && in_pause_left == 0 &&
            !(sample_backlog[0].drain && beats_taken != results_done)) begin
          cur_beat = sample_backlog.pop_front();
          in_valid        <= 1'b1;
          voltage_sample  <= cur_beat.volts;
          comparator_low  <= cur_beat.cmp_low;
          charger_online  <= cur_beat.charger;
          soc_percent     <= cur_beat.soc;
          reminder_active <= cur_beat.reminder;
          in_pause_left = next_pause(in_calm_left);
        end else begin
          in_valid <= 1'b0;
          if (in_pause_left > 0) in_pause_left--;
        end
      end
    end
  end

  // result monitor with random stall
  always @(posedge clk) begin
    supervisor_reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_done));
        end else begin
          want = pending_readings.pop_front();
          compare_field("smoothed_out", results_done, smoothed_out, want.smoothed);
          compare_field("average_out", results_done, average_out, want.average);
          compare_field("phone_level", results_done, phone_level, want.level);
          compare_field("status_out", results_done, status_out, want.status);
          compare_field("shutdown_event", results_done, shutdown_event, want.shutdown_ev);
          compare_field("warning_event", results_done, warning_event, want.warning_ev);
          compare_field("normal_event", results_done, normal_event, want.normal_ev);
          compare_field("charging_event", results_done, charging_event, want.charging_ev);
          compare_field("change_event", results_done, change_event, want.change_ev);
          n_shutdown += want.shutdown_ev;
          n_warning  += want.warning_ev;
          n_normal   += want.normal_ev;
          n_charging += want.charging_ev;
          n_change   += want.change_ev;
        end
        results_done <= results_done + 1;
      end
      if (out_stall_left > 0) begin
        out_stall <= 1'b1;
        out_stall_left--;
      end else begin
        out_stall <= 1'b0;
        out_stall_left = next_pause(out_calm_left);
      end
    end
  end

  // stimulus and phase control
  initial begin
    int sd, wn;

    // mirrored state starts from reset values
    supv_smooth = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) supv_window[i] = '0;
    supv_average = '0;
    supv_rejects = '0;
    supv_ticks = '0;
    supv_off_votes = '0;
    supv_warn_votes = '0;
    supv_reminders = '0;
    supv_shutdowns = '0;
    supv_normals = '0;
    supv_charger_seen = 1'b0;
    supv_first_reminder = 1'b1;
    supv_status = bvs_pkg::ST_NORMAL;
    supv_last_level = LEVEL_W'(LEVEL_MAX);
    thr_shutdown = bvs_pkg::SHUTDOWN_LEVEL_RST;
    thr_warning = bvs_pkg::WARNING_LEVEL_RST;

    // directed opening on reset thresholds
    // first sample loads the smoother, empty window fills, soc above 100
    queue_beat(VOLT_MAX, 1'b0, 1'b0, SOC_TOP, 1'b0, 1'b0);
    queue_beat(VOLT_MAX, 1'b0, 1'b0, 100, 1'b1, 1'b0);
    queue_beat(VOLT_MAX, 1'b1, 1'b0, 101, 1'b0, 1'b0);
    // decay toward zero: outliers rejected until the limit, then taken
    queue_beat(0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 4, 1'b1, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 5, 1'b0, 1'b0);
    queue_beat(0, 1'b0, 1'b1, 14, 1'b0, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 15, 1'b1, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 95, 1'b0, 1'b0);
    queue_beat(0, 1'b1, 1'b1, 50, 1'b1, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 60, 1'b0, 1'b0);
    queue_beat(0, 1'b0, 1'b0, 70, 1'b0, 1'b0);
    // smoother reaches zero, next sample loads directly
    queue_beat(0, 1'b0, 1'b0, 80, 1'b0, 1'b0);
    queue_beat(1, 1'b0, 1'b0, 90, 1'b0, 1'b0);
    // comparator and low voltage push groups into low power
    for (int k = 0; k < 6; k++) queue_beat(335, 1'b1, 1'b0, 20 + k, 1'(k % 2), 1'b0);
    // a charging group reports charging; low power freezes the charger record
    queue_beat(VOLT_MAX, 1'b0, 1'b1, 63, 1'b0, 1'b0);
    queue_beat(VOLT_MAX, 1'b0, 1'b1, 64, 1'b1, 1'b0);
    queue_beat(VOLT_MAX, 1'b0, 1'b1, 99, 1'b0, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // random phases over several threshold settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sd = bvs_pkg::SHUTDOWN_LEVEL_RST; wn = bvs_pkg::WARNING_LEVEL_RST; end
        1: begin sd = 0; wn = 0; end
        2: begin sd = VOLT_MAX; wn = VOLT_MAX; end
        3: begin sd = 0; wn = VOLT_MAX; end
        4: begin sd = 350; wn = 340; end
        default: begin
          sd = $urandom_range(200, 800);
          wn = sd + int'($urandom_range(5, 40));
        end
      endcase
      cfg_write(bvs_pkg::REG_SHUTDOWN_LEVEL, VOLT_W'(sd));
      cfg_write(bvs_pkg::REG_WARNING_LEVEL, VOLT_W'(wn));
      settings_used++;
      queue_episodes(205);
      wait_drained();
    end

    $display("covered %0d sample beats and %0d results over %0d threshold settings",
             beats_taken, results_done, settings_used + 1);
    $display("events seen: shutdown %0d, warning %0d, normal %0d, charging %0d, change %0d",
             n_shutdown, n_warning, n_normal, n_charging, n_change);
    if (error_count == 0) begin
      $display("tb_battery_voltage_supervisor_top: PASS");
    end else begin
      $display("tb_battery_voltage_supervisor_top: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #6_000_000;
    $display("timeout with %0d results still expected", pending_readings.size());
    $display("tb_battery_voltage_supervisor_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bvs_pkg.sv
rtl/battery_voltage_supervisor_top.sv
rtl/bvs_checker.sv
sim/tb_battery_voltage_supervisor_top.sv
